// File: hdl/bpl_pkg.sv
// Shared constants, codes and types for the bounded positional list.
package bpl_pkg;

   localparam int DEPTH   = 16;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int POS_W   = 5;
   localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int FUNC_W  = 3;
   localparam int DATA_W  = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   // request operation codes
   localparam logic [FUNC_W-1:0] FUNC_APPEND    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PREPEND   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_INSERT_AT = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DEL_FIRST = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DEL_LAST  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_DEL_AT    = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_DUMP      = 3'd6;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_ERR  = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INS,
      CELL_DEL,
      CELL_ROT
   } cell_op_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      cell_op_type             op;
      logic [CNT_W-1:0]        idx;
      logic signed [DATA_W-1:0] value;
      logic [CNT_W-1:0]        fill;
   } cell_cmd_type;

endpackage

// File: hdl/bpl_req_if.sv
// Request channel: operation, value and position with valid/ready.
interface bpl_req_if import bpl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [DATA_W-1:0] value;
   logic [POS_W-1:0]         position;

   modport source (output valid, output func, output value, output position, input ready);
   modport sink   (input valid, input func, input value, input position, output ready);
endinterface

// File: hdl/bpl_rsp_if.sv
// Response channel: element, status, count and last marker with valid/ready.
interface bpl_rsp_if import bpl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] element;
   logic [STAT_W-1:0]        status;
   logic [COUNT_W-1:0]       element_count;
   logic                     last;

   modport source (output valid, output element, output status, output element_count,
                   output last, input ready);
   modport sink   (input valid, input element, input status, input element_count,
                   input last, output ready);
endinterface

// File: hdl/bpl_cell.sv
// One list slot: holds an element and takes a new value or a neighbor's on shift commands.
module bpl_cell import bpl_pkg::*; (
   input  logic                     clock,
   input  logic [CNT_W-1:0]         my_idx,
   input  cell_cmd_type             cmd,
   input  logic signed [DATA_W-1:0] left_val,
   input  logic signed [DATA_W-1:0] right_val,
   input  logic signed [DATA_W-1:0] head_val,
   output logic signed [DATA_W-1:0] val
);

   logic signed [DATA_W-1:0] val_ff;
   logic signed [DATA_W-1:0] val_in;
   logic [CNT_W-1:0]         my_next;

   assign my_next = my_idx + CNT_W'(1);

   always_comb begin
      val_in = val_ff;
      case (cmd.op)
         CELL_INS: begin
            if (my_idx == cmd.idx) begin
               val_in = cmd.value;
            end else if (my_idx > cmd.idx && my_idx <= cmd.fill) begin
               val_in = left_val;
            end
         end
         CELL_DEL: begin
            if (my_idx >= cmd.idx && my_next < cmd.fill) begin
               val_in = right_val;
            end
         end
         CELL_ROT: begin
            // rotate live part left by one; tail takes the old head
            if (my_next < cmd.fill) begin
               val_in = right_val;
            end else if (my_next == cmd.fill) begin
               val_in = head_val;
            end
         end
         default: val_in = val_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;

endmodule

// File: hdl/bpl_chain.sv
// Row of DEPTH cells linked to both neighbors; exposes the head element.
module bpl_chain import bpl_pkg::*; (
   input  logic                     clock,
   input  cell_cmd_type             cmd,
   output logic signed [DATA_W-1:0] head
);

   logic signed [DATA_W-1:0] cell_val [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_v;
      logic signed [DATA_W-1:0] right_v;

      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_val[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_val[i+1];
      end

      bpl_cell u_cell (
         .clock     (clock),
         .my_idx    (CNT_W'(i)),
         .cmd       (cmd),
         .left_val  (left_v),
         .right_val (right_v),
         .head_val  (cell_val[0]),
         .val       (cell_val[i])
      );
   end

   assign head = cell_val[0];

endmodule

// File: hdl/bounded_positional_list_top.sv
// Top level of the bounded positional list: control, fill count and response register.
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+--------------------------------------------
//  req_chan  | in  | valid/ready  | func[2:0], value[31:0] signed, position[4:0]
//  rsp_chan  | out | valid/ready  | element[31:0] signed, status[1:0],
//            |     |              | element_count[4:0], last
//
//  An edit request is done on acceptance: every cell shifts in parallel off its
//  position compare, and the single response is registered in the same cycle.
//  A dump takes one request, then answers once per live element (an empty list
//  answers once); the row rotates left by one per response so cell 0 always
//  holds the next element. Synchronous active-high reset clears the fill count
//  and control, not the cell contents. A stalled response holds the dump in place.
module bounded_positional_list_top import bpl_pkg::*; (
   input logic          clock,
   input logic          reset,
   bpl_req_if.sink      req_chan,
   bpl_rsp_if.source    rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [CNT_W-1:0]         dump_cnt_ff, dump_cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_element_ff, rsp_element_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                     rsp_last_ff, rsp_last_in;

   cell_cmd_type             cmd;
   logic signed [DATA_W-1:0] head;

   logic                     out_free;
   logic                     req_ready;
   logic                     req_fire;
   logic                     dump_last;

   // edit decode
   logic [STAT_W-1:0]        ed_status;
   cell_op_type              ed_op;
   logic [CNT_W-1:0]         ed_idx;
   logic [CNT_W-1:0]         ed_fill;
   logic [CMP_W-1:0]         pos_x;
   logic [CMP_W-1:0]         fill_x;
   logic [CNT_W-1:0]         pos_idx;
   logic                     is_full;
   logic                     is_empty;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_chan.valid && req_ready;
   assign dump_last = (dump_cnt_ff == fill_ff - CNT_W'(1));

   assign pos_x    = CMP_W'(req_chan.position);
   assign fill_x   = CMP_W'(fill_ff);
   assign pos_idx  = CNT_W'(pos_x - CMP_W'(1));
   assign is_full  = (fill_ff >= CNT_W'(DEPTH));
   assign is_empty = (fill_ff == '0);

   // status, cell command and new fill for the request at the port
   always_comb begin
      ed_status = STAT_OK;
      ed_op     = CELL_HOLD;
      ed_idx    = '0;
      ed_fill   = fill_ff;
      case (req_chan.func)
         FUNC_APPEND, FUNC_PREPEND, FUNC_INSERT_AT: begin
            if (is_full) begin
               ed_status = STAT_FULL;
            end else if (req_chan.func == FUNC_INSERT_AT &&
                         (pos_x == '0 || pos_x > fill_x + CMP_W'(1))) begin
               ed_status = STAT_ERR;
            end else begin
               ed_op   = CELL_INS;
               ed_fill = fill_ff + CNT_W'(1);
               if (req_chan.func == FUNC_APPEND) begin
                  ed_idx = fill_ff;
               end else if (req_chan.func == FUNC_INSERT_AT) begin
                  ed_idx = pos_idx;
               end
            end
         end
         FUNC_DEL_FIRST, FUNC_DEL_LAST, FUNC_DEL_AT: begin
            if (is_empty) begin
               ed_status = STAT_ERR;
            end else if (req_chan.func == FUNC_DEL_AT &&
                         (pos_x == '0 || pos_x > fill_x)) begin
               ed_status = STAT_ERR;
            end else begin
               ed_op   = CELL_DEL;
               ed_fill = fill_ff - CNT_W'(1);
               if (req_chan.func == FUNC_DEL_LAST) begin
                  ed_idx = fill_ff - CNT_W'(1);
               end else if (req_chan.func == FUNC_DEL_AT) begin
                  ed_idx = pos_idx;
               end
            end
         end
         FUNC_DUMP: ed_status = STAT_OK;  // empty-list dump only; list untouched
         default:   ed_status = STAT_ERR;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      dump_cnt_in    = dump_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_element_in = rsp_element_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      cmd.op         = CELL_HOLD;
      cmd.idx        = ed_idx;
      cmd.value      = req_chan.value;
      cmd.fill       = fill_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.func == FUNC_DUMP && !is_empty) begin
                  state_in    = ST_DUMP;
                  dump_cnt_in = '0;
               end else begin
                  cmd.op         = ed_op;
                  fill_in        = ed_fill;
                  rsp_valid_in   = 1'b1;
                  rsp_element_in = '0;
                  rsp_status_in  = ed_status;
                  rsp_count_in   = COUNT_W'(ed_fill);
                  rsp_last_in    = 1'b1;
               end
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               cmd.op         = CELL_ROT;
               dump_cnt_in    = dump_cnt_ff + CNT_W'(1);
               rsp_valid_in   = 1'b1;
               rsp_element_in = head;
               rsp_status_in  = STAT_OK;
               rsp_count_in   = COUNT_W'(fill_ff);
               rsp_last_in    = dump_last;
               if (dump_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         dump_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dump_cnt_ff  <= dump_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_element_ff <= rsp_element_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   bpl_chain u_chain (
      .clock (clock),
      .cmd   (cmd),
      .head  (head)
   );

   assign req_chan.ready         = req_ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.element       = rsp_element_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.element_count = rsp_count_ff;
   assign rsp_chan.last          = rsp_last_ff;

   // fill never runs past the row
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   // a dump never edits the list
   a_dump_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |=> fill_ff == $past(fill_ff))
      else $error("fill changed during dump");

   // dump walk stays within the live elements
   a_dump_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DUMP |-> dump_cnt_ff < fill_ff)
      else $error("dump index past tail");

   // only a dump in flight leaves a response without the last marker
   a_nonlast_in_dump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> state_ff == ST_DUMP)
      else $error("non-final response outside dump");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

// Self-checking testbench for the bounded positional list: random edits, dumps and handshake stalls.
module testbench;
   import bpl_pkg::*;

   // selector 7 has no operation behind it; the block must answer with an error
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;
   localparam int RANDOM_REQS      = 200;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int MAX_REPORTS      = 40;

   // one request as queued for the driver
   typedef struct {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      bit                       drain_first;  // hold off until every response is back
   } list_req_type;

   // one response as the block should produce it
   typedef struct {
      logic signed [DATA_W-1:0] element;
      logic [STAT_W-1:0]        status;
      logic [COUNT_W-1:0]       element_count;
      logic                     last;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpl_req_if req_chan ();
   bpl_rsp_if rsp_chan ();

   bounded_positional_list_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   list_req_type req_backlog [$];   // requests not yet accepted by the block
   list_rsp_type awaited_rsps [$];  // responses predicted but not yet seen

   // shadow copy of the list, advanced on every accepted request
   logic signed [DATA_W-1:0] list_cells [DEPTH];
   int list_len   = 0;
   // element count the stimulus builder expects, used only to aim positions
   int plan_len   = 0;

   int fail_count = 0;
   int reports    = 0;
   int rsp_seen   = 0;

   // ------------------------------------------------------------------
   // List predictor
   // ------------------------------------------------------------------
   function automatic void push_rsp(logic signed [DATA_W-1:0] elem, logic [STAT_W-1:0] st,
                                    logic lst);
      list_rsp_type r;
      r.element       = elem;
      r.status        = st;
      r.element_count = COUNT_W'(list_len);
      r.last          = lst;
      awaited_rsps.push_back(r);
   endfunction

   // Applies one accepted request to the shadow list and queues its responses.
   function automatic void predict_list(list_req_type r);
      logic [STAT_W-1:0] st;
      int slot;
      int k;
      st = STAT_OK;
      case (r.func)
         FUNC_APPEND, FUNC_PREPEND, FUNC_INSERT_AT: begin
            // full is checked ahead of the position
            if (list_len >= DEPTH) begin
               st = STAT_FULL;
            end else begin
               if (r.func == FUNC_APPEND)
                  slot = list_len;
               else if (r.func == FUNC_PREPEND)
                  slot = 0;
               else
                  slot = int'(r.position) - 1;
               if (slot < 0 || slot > list_len) begin
                  st = STAT_ERR;
               end else begin
                  for (k = list_len; k > slot; k--)
                     list_cells[k] = list_cells[k-1];
                  list_cells[slot] = r.value;
                  list_len++;
               end
            end
         end
         FUNC_DEL_FIRST, FUNC_DEL_LAST, FUNC_DEL_AT: begin
            if (r.func == FUNC_DEL_FIRST)
               slot = 0;
            else if (r.func == FUNC_DEL_LAST)
               slot = list_len - 1;
            else
               slot = int'(r.position) - 1;
            if (list_len == 0 || slot < 0 || slot >= list_len) begin
               st = STAT_ERR;
            end else begin
               for (k = slot; k + 1 < list_len; k++)
                  list_cells[k] = list_cells[k+1];
               list_len--;
            end
         end
         FUNC_DUMP: begin
            // an empty list still answers once, with a zero element
            if (list_len == 0) begin
               push_rsp('0, STAT_OK, 1'b1);
            end else begin
               for (k = 0; k < list_len; k++)
                  push_rsp(list_cells[k], STAT_OK, k == list_len - 1);
            end
            return;
         end
         default: st = STAT_ERR;
      endcase
      push_rsp('0, st, 1'b1);
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   // values lean on the two's complement corners now and then
   function automatic logic signed [DATA_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return -32'sd1;
         3: return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   // mostly a legal 1-based position up to top, sometimes zero or past the end
   function automatic int pick_pos(int top);
      if (top >= 1 && $urandom_range(0, 6) != 0)
         return $urandom_range(1, top);
      if (top >= 17 || $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(top + 1, 17);
   endfunction

   function automatic void queue_req(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] v,
                                     int p, bit drain);
      list_req_type r;
      r.func        = f;
      r.value       = v;
      r.position    = POS_W'(p);
      r.drain_first = drain;
      req_backlog.push_back(r);
      case (f)
         FUNC_APPEND, FUNC_PREPEND:
            if (plan_len < DEPTH) plan_len++;
         FUNC_INSERT_AT:
            if (plan_len < DEPTH && p >= 1 && p <= plan_len + 1) plan_len++;
         FUNC_DEL_FIRST, FUNC_DEL_LAST:
            if (plan_len > 0) plan_len--;
         FUNC_DEL_AT:
            if (p >= 1 && p <= plan_len) plan_len--;
         default: ;
      endcase
   endfunction

   function automatic void queue_grow_req(bit drain);
      case ($urandom_range(0, 2))
         0: queue_req(FUNC_APPEND, rand_value(), $urandom_range(0, 17), drain);
         1: queue_req(FUNC_PREPEND, rand_value(), $urandom_range(0, 17), drain);
         default: queue_req(FUNC_INSERT_AT, rand_value(), pick_pos(plan_len + 1), drain);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request driver: presents the backlog head, predicts on acceptance
   // ------------------------------------------------------------------
   int send_gap    = 0;
   bit sender_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_list(req_backlog.pop_front());
            // flip now and then into a stretch of back-to-back requests
            if ($urandom_range(0, 19) == 0)
               sender_calm = !sender_calm;
            send_gap = sender_calm ? 0 : draw_gap();
         end
         // a request still waiting for ready stays on the bus untouched
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].drain_first && awaited_rsps.size() != 0)) begin
               req_chan.valid    <= 1'b1;
               req_chan.func     <= req_backlog[0].func;
               req_chan.value    <= req_backlog[0].value;
               req_chan.position <= req_backlog[0].position;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: checks against the oldest prediction, throttles ready
   // ------------------------------------------------------------------
   int hold_cnt        = 0;
   bit rsp_calm        = 1'b0;
   bit long_hold_done  = 1'b0;
   list_rsp_type want_rsp;

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_cnt = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_seen++;
            if (awaited_rsps.size() == 0) begin
               fail_count++;
               if (reports < MAX_REPORTS)
                  $display("%0t: unexpected response: element %0d status %0d count %0d last %0b",
                           $time, rsp_chan.element, rsp_chan.status,
                           rsp_chan.element_count, rsp_chan.last);
               reports++;
            end else begin
               want_rsp = awaited_rsps.pop_front();
               if (rsp_chan.element !== want_rsp.element ||
                   rsp_chan.status !== want_rsp.status ||
                   rsp_chan.element_count !== want_rsp.element_count ||
                   rsp_chan.last !== want_rsp.last) begin
                  fail_count++;
                  if (reports < MAX_REPORTS)
                     $display({"%0t: response mismatch: expected element %0d status %0d ",
                               "count %0d last %0b, got element %0d status %0d count %0d ",
                               "last %0b"},
                              $time, want_rsp.element, want_rsp.status,
                              want_rsp.element_count, want_rsp.last, rsp_chan.element,
                              rsp_chan.status, rsp_chan.element_count, rsp_chan.last);
                  reports++;
               end
            end
         end
         // one long hold-off while requests keep coming, so the block backs up
         if (!long_hold_done && rsp_seen >= 40 && req_chan.valid) begin
            long_hold_done = 1'b1;
            hold_cnt = LONG_HOLD_CYCLES;
         end else if (hold_cnt == 0 && !rsp_calm && $urandom_range(0, 3) == 0) begin
            hold_cnt = draw_gap();
         end
         if ($urandom_range(0, 49) == 0)
            rsp_calm = !rsp_calm;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------
   initial begin
      int directed_n;
      int ep;
      int kind;
      int len;
      int k;
      bit drain;
      logic [FUNC_W-1:0] f;

      req_chan.valid    = 1'b0;
      req_chan.func     = FUNC_APPEND;
      req_chan.value    = '0;
      req_chan.position = '0;
      rsp_chan.ready    = 1'b0;

      // directed: errors on the empty list, edge positions, extremes, unused selector
      queue_req(FUNC_DUMP,      32'sd0,        0, 1'b0);  // dump of an empty list
      queue_req(FUNC_DEL_FIRST, 32'sd0,        1, 1'b0);
      queue_req(FUNC_DEL_LAST,  32'sd0,        1, 1'b0);
      queue_req(FUNC_DEL_AT,    32'sd0,        1, 1'b0);
      queue_req(FUNC_INSERT_AT, 32'sd5,        0, 1'b0);  // position zero
      queue_req(FUNC_INSERT_AT, 32'sd5,        2, 1'b0);  // past fill+1
      queue_req(FUNC_INSERT_AT, 32'sh7fff_ffff, 1, 1'b0);
      queue_req(FUNC_APPEND,    32'sh8000_0000, 31, 1'b0);
      queue_req(FUNC_PREPEND,   -32'sd1,      17, 1'b0);
      queue_req(FUNC_INSERT_AT, 32'sd0,        4, 1'b0);  // exactly fill+1
      queue_req(FUNC_INSERT_AT, 32'sh5555_5555, 2, 1'b0);
      queue_req(FUNC_DUMP,      32'sh2aaa_aaaa, 10, 1'b0);
      queue_req(FUNC_DEL_AT,    32'sd0,        0, 1'b0);
      queue_req(FUNC_DEL_AT,    32'sd0,        6, 1'b0);  // one past fill
      queue_req(FUNC_DEL_AT,    32'sd0,       17, 1'b0);
      queue_req(FUNC_DEL_AT,    32'sd0,        3, 1'b0);
      queue_req(FUNC_DEL_AT,    32'sd0,        4, 1'b0);  // the tail by position
      queue_req(FUNC_UNUSED,    32'sh1234_5678, 9, 1'b0);
      queue_req(FUNC_DEL_FIRST, 32'sd0,        0, 1'b0);
      queue_req(FUNC_DEL_LAST,  32'sd0,        0, 1'b0);
      queue_req(FUNC_DUMP,      32'sd0,        0, 1'b0);  // single element
      queue_req(FUNC_DEL_AT,    32'sd0,        1, 1'b0);
      queue_req(FUNC_DUMP,      32'sd0,       16, 1'b0);
      directed_n = req_backlog.size();

      // random episodes: grow, shrink, noise, or fill to the brim and push on it.
      // The first episode fills up and waits for the directed part to drain.
      ep = 0;
      while (req_backlog.size() < directed_n + RANDOM_REQS) begin
         kind  = (ep == 0) ? 9 : $urandom_range(0, 9);
         len   = $urandom_range(4, 20);
         drain = (ep == 0) || ($urandom_range(0, 4) == 0);
         if (kind == 9) begin
            while (plan_len < DEPTH) begin
               queue_grow_req(drain);
               drain = 1'b0;
            end
            queue_req(FUNC_APPEND, rand_value(), $urandom_range(0, 17), 1'b0);
            queue_req(FUNC_PREPEND, rand_value(), $urandom_range(0, 17), 1'b0);
            queue_req(FUNC_INSERT_AT, rand_value(), $urandom_range(0, 17), 1'b0);
            queue_req(FUNC_DUMP, rand_value(), $urandom_range(0, 17), 1'b0);
            queue_req(FUNC_DEL_AT, rand_value(), DEPTH, 1'b0);
            queue_req(FUNC_INSERT_AT, rand_value(), DEPTH + 1, 1'b0);  // one past fill+1
            queue_req(FUNC_INSERT_AT, rand_value(), DEPTH, 1'b0);
            queue_req(FUNC_DUMP, rand_value(), $urandom_range(0, 17), 1'b0);
         end else begin
            for (k = 0; k < len; k++) begin
               if ($urandom_range(0, 9) == 9) begin
                  queue_req(FUNC_DUMP, rand_value(), $urandom_range(0, 17), drain);
               end else if (kind < 4) begin
                  queue_grow_req(drain);
               end else if (kind < 7) begin
                  case ($urandom_range(0, 2))
                     0: queue_req(FUNC_DEL_FIRST, rand_value(), $urandom_range(0, 17), drain);
                     1: queue_req(FUNC_DEL_LAST, rand_value(), $urandom_range(0, 17), drain);
                     default: queue_req(FUNC_DEL_AT, rand_value(), pick_pos(plan_len), drain);
                  endcase
               end else begin
                  if ($urandom_range(0, 19) == 0)
                     f = FUNC_UNUSED;
                  else
                     f = FUNC_W'($urandom_range(FUNC_APPEND, FUNC_DUMP));
                  queue_req(f, rand_value(), $urandom_range(0, 17), drain);
               end
               drain = 1'b0;
            end
         end
         ep++;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // everything accepted and answered, then let a full dump's worth of cycles pass
      while (req_backlog.size() != 0 || awaited_rsps.size() != 0)
         @(posedge clock);
      repeat (2 * DEPTH + 8) @(posedge clock);

      if (fail_count == 0)
         $display("** bounded_positional_list_top: PASSED **");
      else
         $display("** bounded_positional_list_top: FAILED **");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("** bounded_positional_list_top: FAILED **");
      $finish;
   end

endmodule
